>>> rtl/ccs_pkg.sv
`timescale 1ns / 1ps
// Package for the C comment stripper: transaction types, lexer states and byte codes.
// Used by ccs_lexer and c_comment_stripper_core; depends on nothing else.
package ccs_pkg;

  localparam int ERR_LINE_BITS = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [7:0] {
    ST_NORMAL   = 8'b0000_0001,
    ST_SLASH    = 8'b0000_0010,
    ST_COMMENT  = 8'b0000_0100,
    ST_STAR     = 8'b0000_1000,
    ST_CHAR     = 8'b0001_0000,
    ST_CHAR_ESC = 8'b0010_0000,
    ST_STR      = 8'b0100_0000,
    ST_STR_ESC  = 8'b1000_0000
  } lex_state_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]               out_char;
    logic                     char_valid;
    logic                     last_of_run;
    logic                     text_done;
    logic                     unterminated;
    logic [ERR_LINE_BITS-1:0] error_line;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } lex_out_t;

  function automatic out_item_t char_item(input logic [7:0] c);
    out_item_t r;
    r              = '0;
    r.out_char     = c;
    r.char_valid   = 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/ccs_lexer.sv
`timescale 1ns / 1ps
// Comment-removal lexer: state, line counter and the results of one byte.
// Depends on ccs_pkg.
module ccs_lexer #(
  parameter int LINE_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ccs_pkg::in_item_t item,
  output ccs_pkg::lex_out_t res
);
  import ccs_pkg::*;

  lex_state_t           state, state_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [LINE_BITS-1:0] comment_line, comment_line_next;
  logic                 bump;
  logic [7:0]           c;
  logic [LINE_BITS+ERR_LINE_BITS-1:0] cline_wide;
  out_item_t            status;

  assign c          = item.in_char;
  assign cline_wide = {{ERR_LINE_BITS{1'b0}}, comment_line};

  always_comb begin
    status              = '0;
    status.text_done    = 1'b1;
    status.unterminated = (state == ST_COMMENT) || (state == ST_STAR);
    if (status.unterminated) begin
      status.error_line = cline_wide[ERR_LINE_BITS-1:0];
    end
  end

  always_comb begin
    state_next        = state;
    comment_line_next = comment_line;
    bump              = 1'b0;
    res               = '0;
    if (item.end_of_text) begin
      if (state == ST_SLASH) begin
        res.count  = 2'd2;
        res.first  = char_item(CH_SLASH);
        res.second = status;
      end else begin
        res.count = 2'd1;
        res.first = status;
      end
      state_next = ST_NORMAL;
    end else begin
      case (state)
        ST_NORMAL: begin
          if (c == CH_SLASH) begin
            state_next = ST_SLASH;
          end else begin
            res.count = 2'd1;
            res.first = char_item(c);
            if (c == CH_NL) begin
              bump = 1'b1;
            end else if (c == CH_QUOTE) begin
              state_next = ST_CHAR;
            end else if (c == CH_DQUOTE) begin
              state_next = ST_STR;
            end
          end
        end
        ST_SLASH: begin
          if (c == CH_STAR) begin
            res.count         = 2'd1;
            res.first         = char_item(CH_SPACE);
            comment_line_next = line_count;
            state_next        = ST_COMMENT;
          end else if (c == CH_SLASH) begin
            res.count = 2'd1;
            res.first = char_item(CH_SLASH);
          end else begin
            res.count  = 2'd2;
            res.first  = char_item(CH_SLASH);
            res.second = char_item(c);
            if (c == CH_NL) begin
              bump       = 1'b1;
              state_next = ST_NORMAL;
            end else if (c == CH_QUOTE) begin
              state_next = ST_CHAR;
            end else if (c == CH_DQUOTE) begin
              state_next = ST_STR;
            end else begin
              state_next = ST_NORMAL;
            end
          end
        end
        ST_COMMENT: begin
          if (c == CH_STAR) begin
            state_next = ST_STAR;
          end else if (c == CH_NL) begin
            res.count = 2'd1;
            res.first = char_item(CH_NL);
            bump      = 1'b1;
          end
        end
        ST_STAR: begin
          if (c == CH_SLASH) begin
            state_next = ST_NORMAL;
          end else if (c != CH_STAR) begin
            if (c == CH_NL) begin
              res.count = 2'd1;
              res.first = char_item(CH_NL);
              bump      = 1'b1;
            end
            state_next = ST_COMMENT;
          end
        end
        ST_CHAR, ST_STR: begin
          res.count = 2'd1;
          res.first = char_item(c);
          if (c == CH_NL) begin
            bump = 1'b1;
          end else if (c == CH_BSLASH) begin
            state_next = (state == ST_CHAR) ? ST_CHAR_ESC : ST_STR_ESC;
          end else if (c == ((state == ST_CHAR) ? CH_QUOTE : CH_DQUOTE)) begin
            state_next = ST_NORMAL;
          end
        end
        ST_CHAR_ESC, ST_STR_ESC: begin
          res.count  = 2'd1;
          res.first  = char_item(c);
          bump       = (c == CH_NL);
          state_next = (state == ST_CHAR_ESC) ? ST_CHAR : ST_STR;
        end
        default: begin
          state_next = ST_NORMAL;
        end
      endcase
    end
    if (res.count == 2'd2) begin
      res.second.last_of_run = 1'b1;
    end else if (res.count == 2'd1) begin
      res.first.last_of_run = 1'b1;
    end
  end

  always_comb begin
    line_count_next = line_count;
    if (item.end_of_text) begin
      line_count_next = LINE_BITS'(1);
    end else if (bump && (line_count != {LINE_BITS{1'b1}})) begin
      line_count_next = line_count + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_NORMAL;
      line_count   <= LINE_BITS'(1);
      comment_line <= '0;
    end else if (step) begin
      state        <= state_next;
      line_count   <= line_count_next;
      comment_line <= item.end_of_text ? '0 : comment_line_next;
    end
  end

endmodule

>>> rtl/c_comment_stripper_core.sv
`timescale 1ns / 1ps
// Top level of the C comment stripper: lexer plus a four-entry result queue.
// Depends on ccs_pkg and ccs_lexer.

// The block accepts one source byte per cycle. The first result of a byte can
// be taken in the cycle after the byte is accepted, from a four-entry result
// queue. Each byte yields zero, one or two results, and end of text yields
// the status result, after a flushed slash when one is held. A byte is taken
// whenever the queue holds at most two results. With the consumer always
// ready the queue never holds more than two, so the input never stalls. It
// stalls only after consumer stalls have left three or more results waiting.
module c_comment_stripper_core #(
  parameter int LINE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ccs_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ccs_pkg::out_item_t result
);
  import ccs_pkg::*;

  out_item_t                 queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] head, tail;
  logic [QUEUE_PTR_BITS:0]   count, count_next;
  logic                      accept, pop;
  lex_out_t                  lex_res;
  logic [QUEUE_PTR_BITS:0]   push_count;

  assign item_ready   = count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2);
  assign accept       = item_valid && item_ready;
  assign result_valid = count != '0;
  assign pop          = result_valid && result_ready;
  assign result       = queue[head];
  assign push_count   = accept ? (QUEUE_PTR_BITS+1)'(lex_res.count) : '0;
  assign count_next   = count + push_count - (QUEUE_PTR_BITS+1)'(pop);

  ccs_lexer #(.LINE_BITS(LINE_BITS)) u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .item (item),
    .res  (lex_res)
  );

  always_ff @(posedge clk) begin
    if (accept && (lex_res.count != 2'd0)) begin
      queue[tail] <= lex_res.first;
      if (lex_res.count == 2'd2) begin
        queue[tail + QUEUE_PTR_BITS'(1)] <= lex_res.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      tail  <= tail + push_count[QUEUE_PTR_BITS-1:0];
      if (pop) begin
        head <= head + QUEUE_PTR_BITS'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_eot_yields_result: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_text) |=> result_valid)
    else $error("end of text produced no status result");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.text_done) |-> (!result.char_valid && result.last_of_run))
    else $error("malformed status result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && (count > (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2))))
    else $error("input stalled with room in the queue");
`endif

endmodule
